### hw/rtl/dfir_pkg.sv
// Shared constants, types and the coefficient table for the decimating I/Q FIR.
// Used by the top level, dfir_ctrl and dfir_lane; no dependencies.
package dfir_pkg;

  localparam int TAPS         = 37;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 18;
  localparam int ACC_WIDTH    = 40;
  localparam int DECIM_MAX    = 64;
  localparam int DECIM_RESET  = 6;
  localparam int HALF_LEN     = (TAPS + 1) / 2;

  // Digit-serial multiply: sample enters the MAC this many bits per cycle
  localparam int DIGIT_WIDTH  = 4;
  localparam int NUM_DIGITS   = SAMPLE_WIDTH / DIGIT_WIDTH;
  localparam int DIGIT_CNT_W  = $clog2(NUM_DIGITS);

  localparam int TAP_W        = $clog2(TAPS);
  localparam int HALF_W       = $clog2(HALF_LEN);
  localparam int COUNT_W      = $clog2(DECIM_MAX);
  localparam int DEC_W        = COUNT_W + 1;

  localparam int TERM_W       = COEF_WIDTH + DIGIT_WIDTH + 1;
  localparam int PROD_W       = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int RSUM_W       = ACC_WIDTH + 1;
  localparam int RQ_W         = RSUM_W - (COEF_WIDTH - 1);

  localparam logic signed [RSUM_W-1:0] ROUND_HALF = RSUM_W'(1) <<< (COEF_WIDTH - 2);
  localparam logic signed [RQ_W-1:0]   SAT_HI = RQ_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [RQ_W-1:0]   SAT_LO = -SAT_HI - RQ_W'(1);

  // APB register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_DECIMATION = 1'b0;

  // First half of the symmetric low-pass table, center last, signed Q0.17
  localparam logic signed [COEF_WIDTH-1:0] HALF_COEF [HALF_LEN] = '{
    -18'sd37,   -18'sd33,   18'sd46,    18'sd225,   18'sd462,
    18'sd630,   18'sd543,   18'sd33,    -18'sd925,  -18'sd2113,
    -18'sd3042, -18'sd3054, -18'sd1530, 18'sd1847,  18'sd6877,
    18'sd12794, 18'sd18411, 18'sd22445, 18'sd23913
  };

  typedef struct packed {
    logic             we;
    logic [TAP_W-1:0] waddr;
    logic             re;
    logic [TAP_W-1:0] raddr;
  } ram_ctrl_t;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic load;    // take a new sample into the digit shift register
    logic step;    // process one digit
    logic first;   // digit is the signed top digit
    logic last;    // digit is the last one of the tap
  } lane_ctrl_t;

  // Fold the tap index onto the stored half of the table
  function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [TAP_W-1:0] k);
    logic [TAP_W-1:0] mirror;
    logic [TAP_W-1:0] m;
    mirror = TAP_W'(TAPS - 1) - k;
    m      = (k < mirror) ? k : mirror;
    return HALF_COEF[m[HALF_W-1:0]];
  endfunction

endpackage

### hw/rtl/decimating_iq_fir_lowpass.sv
// Decimating 37-tap complex low-pass FIR, top level: APB register, delay RAM, two lanes.
// Depends on dfir_pkg, dfir_ram, dfir_ctrl and dfir_lane.
// Flow: an input that gives no result is taken while s_tready stays high; an input that gives a
//   result holds s_tready low while the sequencer reads the RAM and walks 37 taps of 4 digits
//   each on the shared per-rail multiplier, then waits in ST_DONE until the output register is free.
// m_tvalid rises once the last tap of the triggering input is done and the output register is free.
// Reset (synchronous, rst high): delay line reads as zero, slot and count clear, decimation 6.
module decimating_iq_fir_lowpass (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfir_pkg::PADDR_W-1:0]  paddr,
  input  logic [dfir_pkg::PDATA_W-1:0]  pwdata,
  output logic [dfir_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // [15:0] in_i, [31:16] in_q
  // output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata    // [15:0] out_i, [31:16] out_q
);

  localparam int SW = dfir_pkg::SAMPLE_WIDTH;

  logic [dfir_pkg::DEC_W-1:0]              decimation;
  logic                                    reg_index;
  logic                                    cfg_write;
  logic                                    in_fire;
  logic                                    out_free;
  dfir_pkg::ram_ctrl_t                     ram;
  dfir_pkg::lane_ctrl_t                    lane;
  logic signed [dfir_pkg::COEF_WIDTH-1:0]  coef;
  logic                                    rd_valid;
  logic                                    done;
  logic [2*SW-1:0]                         rdata;
  logic signed [SW-1:0]                    sample_i;
  logic signed [SW-1:0]                    sample_q;
  logic signed [SW-1:0]                    result_i;
  logic signed [SW-1:0]                    result_q;

  // Configuration: one register per word, index from the word address
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready
                     && (reg_index == dfir_pkg::REG_DECIMATION);

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation <= dfir_pkg::DEC_W'(dfir_pkg::DECIM_RESET);
    end else if (cfg_write) begin
      decimation <= pwdata[dfir_pkg::DEC_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_index)
      dfir_pkg::REG_DECIMATION: prdata = dfir_pkg::PDATA_W'(decimation);
      default:                  prdata = '0;
    endcase
  end

  assign in_fire  = s_tvalid && s_tready;
  // The output register can take a new result when empty or being drained
  assign out_free = !m_tvalid || m_tready;

  dfir_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .decimation (decimation),
    .in_fire    (in_fire),
    .out_free   (out_free),
    .in_ready   (s_tready),
    .ram        (ram),
    .lane       (lane),
    .coef       (coef),
    .rd_valid   (rd_valid),
    .done       (done)
  );

  // Delay line: both rails side by side in one word per slot
  dfir_ram #(
    .WIDTH (2 * SW),
    .DEPTH (dfir_pkg::TAPS)
  ) u_delay (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (s_tdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  // A slot never written since reset reads as zero
  assign sample_i = rd_valid ? rdata[SW-1:0]    : '0;
  assign sample_q = rd_valid ? rdata[2*SW-1:SW] : '0;

  dfir_lane u_lane_i (
    .clk    (clk),
    .ctrl   (lane),
    .sample (sample_i),
    .coef   (coef),
    .result (result_i)
  );

  dfir_lane u_lane_q (
    .clk    (clk),
    .ctrl   (lane),
    .sample (sample_q),
    .coef   (coef),
    .result (result_q)
  );

  // Output register: hold the result until the downstream transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {result_q, result_i};
    end
  end

endmodule

### hw/rtl/dfir_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 37
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/dfir_lane.sv
// One rail of the filter: digit-serial multiply, 40-bit accumulate, round and saturate.
// Depends on dfir_pkg.
module dfir_lane (
  input  logic                                    clk,
  input  dfir_pkg::lane_ctrl_t                    ctrl,
  input  logic signed [dfir_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic signed [dfir_pkg::COEF_WIDTH-1:0]   coef,
  output logic signed [dfir_pkg::SAMPLE_WIDTH-1:0] result
);

  logic [dfir_pkg::SAMPLE_WIDTH-1:0]        shreg;
  logic signed [dfir_pkg::PROD_W-1:0]       prod;
  logic signed [dfir_pkg::PROD_W-1:0]       prod_next;
  logic signed [dfir_pkg::ACC_WIDTH-1:0]    acc;
  logic signed [dfir_pkg::ACC_WIDTH-1:0]    acc_next;
  logic [dfir_pkg::DIGIT_WIDTH-1:0]         digit;
  logic signed [dfir_pkg::DIGIT_WIDTH:0]    digit_s;
  logic signed [dfir_pkg::TERM_W-1:0]       term;
  logic signed [dfir_pkg::RSUM_W-1:0]       rsum;
  logic signed [dfir_pkg::RQ_W-1:0]         rq;

  // Horner over digits, most significant first; only the top digit is signed
  assign digit     = shreg[dfir_pkg::SAMPLE_WIDTH-1 -: dfir_pkg::DIGIT_WIDTH];
  assign digit_s   = ctrl.first ? {digit[dfir_pkg::DIGIT_WIDTH-1], digit} : {1'b0, digit};
  assign term      = coef * digit_s;
  assign prod_next = (ctrl.first ? '0 : (prod <<< dfir_pkg::DIGIT_WIDTH))
                     + dfir_pkg::PROD_W'(term);
  assign acc_next  = acc + dfir_pkg::ACC_WIDTH'(prod_next);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shreg <= sample;
    end else if (ctrl.step) begin
      shreg <= shreg << dfir_pkg::DIGIT_WIDTH;
    end
    if (ctrl.step) begin
      prod <= prod_next;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.step && ctrl.last) begin
      acc <= acc_next;
    end
  end

  // Round half up to Q1.15, then clamp
  assign rsum = dfir_pkg::RSUM_W'(acc) + dfir_pkg::ROUND_HALF;
  assign rq   = rsum[dfir_pkg::RSUM_W-1:dfir_pkg::COEF_WIDTH-1];

  always_comb begin
    priority if (rq > dfir_pkg::SAT_HI) begin
      result = dfir_pkg::SAT_HI[dfir_pkg::SAMPLE_WIDTH-1:0];
    end else if (rq < dfir_pkg::SAT_LO) begin
      result = dfir_pkg::SAT_LO[dfir_pkg::SAMPLE_WIDTH-1:0];
    end else begin
      result = rq[dfir_pkg::SAMPLE_WIDTH-1:0];
    end
  end

endmodule

### hw/rtl/dfir_ctrl.sv
// Sequencer: delay-line slot pointer, decimation counter, valid bits, tap and digit walk.
// Depends on dfir_pkg.
module dfir_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [dfir_pkg::DEC_W-1:0]        decimation,
  input  logic                              in_fire,
  input  logic                              out_free,
  output logic                              in_ready,
  output dfir_pkg::ram_ctrl_t               ram,
  output dfir_pkg::lane_ctrl_t              lane,
  output logic signed [dfir_pkg::COEF_WIDTH-1:0] coef,
  output logic                              rd_valid,
  output logic                              done
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_MAC  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                          state, state_next;
  logic [dfir_pkg::TAP_W-1:0]      write_slot, write_slot_next;
  logic [dfir_pkg::COUNT_W-1:0]    input_count, input_count_next;
  logic [dfir_pkg::TAP_W-1:0]      rd_slot, rd_slot_next;
  logic [dfir_pkg::TAP_W-1:0]      tap, tap_next;
  logic [dfir_pkg::DIGIT_CNT_W-1:0] digit, digit_next;
  logic [dfir_pkg::TAPS-1:0]       valid;

  logic [dfir_pkg::DEC_W-1:0]      eff;
  logic [dfir_pkg::DEC_W-1:0]      cnt_inc;
  logic                            due;
  logic [dfir_pkg::TAP_W-1:0]      ws_inc;
  logic [dfir_pkg::TAP_W-1:0]      nxt_slot;
  logic                            last_tap;
  logic                            last_digit;
  logic                            prefetch;

  // Zero acts as one, anything above the maximum as the maximum
  always_comb begin
    priority if (decimation == '0) begin
      eff = dfir_pkg::DEC_W'(1);
    end else if (decimation > dfir_pkg::DEC_W'(dfir_pkg::DECIM_MAX)) begin
      eff = dfir_pkg::DEC_W'(dfir_pkg::DECIM_MAX);
    end else begin
      eff = decimation;
    end
  end

  assign cnt_inc    = {1'b0, input_count} + dfir_pkg::DEC_W'(1);
  assign due        = cnt_inc >= eff;
  assign ws_inc     = (write_slot == dfir_pkg::TAP_W'(dfir_pkg::TAPS - 1)) ? '0
                      : write_slot + dfir_pkg::TAP_W'(1);
  assign nxt_slot   = (rd_slot == '0) ? dfir_pkg::TAP_W'(dfir_pkg::TAPS - 1)
                      : rd_slot - dfir_pkg::TAP_W'(1);
  assign last_tap   = tap == dfir_pkg::TAP_W'(dfir_pkg::TAPS - 1);
  assign last_digit = digit == dfir_pkg::DIGIT_CNT_W'(dfir_pkg::NUM_DIGITS - 1);
  assign prefetch   = digit == dfir_pkg::DIGIT_CNT_W'(dfir_pkg::NUM_DIGITS - 2);
  assign coef       = dfir_pkg::coef_at(tap);

  always_comb begin
    state_next       = state;
    write_slot_next  = write_slot;
    input_count_next = input_count;
    rd_slot_next     = rd_slot;
    tap_next         = tap;
    digit_next       = digit;
    in_ready         = 1'b0;
    done             = 1'b0;
    ram.we           = 1'b0;
    ram.waddr        = write_slot;
    ram.re           = 1'b0;
    ram.raddr        = rd_slot;
    lane             = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ram.we          = 1'b1;
          write_slot_next = ws_inc;
          if (due) begin
            input_count_next = '0;
            rd_slot_next     = write_slot;
            tap_next         = '0;
            lane.clear       = 1'b1;
            state_next       = ST_READ;
          end else begin
            input_count_next = cnt_inc[dfir_pkg::COUNT_W-1:0];
          end
        end
      end
      ST_READ: begin
        ram.re     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        lane.load  = 1'b1;
        digit_next = '0;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        lane.step  = 1'b1;
        lane.first = digit == '0;
        lane.last  = last_digit;
        digit_next = digit + dfir_pkg::DIGIT_CNT_W'(1);
        // fetch the next tap's sample so it lands as this tap finishes
        if (prefetch && !last_tap) begin
          ram.re    = 1'b1;
          ram.raddr = nxt_slot;
        end
        if (last_digit) begin
          digit_next = '0;
          if (last_tap) begin
            state_next = ST_DONE;
          end else begin
            lane.load    = 1'b1;
            tap_next     = tap + dfir_pkg::TAP_W'(1);
            rd_slot_next = nxt_slot;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_slot  <= '0;
      input_count <= '0;
      valid       <= '0;
      rd_valid    <= 1'b0;
    end else begin
      state       <= state_next;
      write_slot  <= write_slot_next;
      input_count <= input_count_next;
      if (ram.we) begin
        valid[ram.waddr] <= 1'b1;
      end
      if (ram.re) begin
        rd_valid <= valid[ram.raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= rd_slot_next;
    tap     <= tap_next;
    digit   <= digit_next;
  end

endmodule
